[hw/rtl/lsh_pkg.sv]
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants and types of the 3x3 Laplacian sharpen core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
   localparam int CH_W         = 8;
   localparam int PIX_W        = 3 * CH_W;
   localparam int WORD_W       = 32;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 13;
   localparam int RSP_DEPTH    = 3;
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1);
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_DRAIN = 1'b1
   } kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] centre;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] down;
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] right;
   } window_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } rsp_item_type;

   typedef struct packed {
      kind_type         kind;
      logic             emit;
      logic             interior;
      logic             frame_end;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] down;
   } stage_type;

endpackage

`default_nettype wire

[hw/rtl/lsh_stream_if.sv]
// ----------------------------------------------------------------------------
// lsh_stream_if
// Valid/ready channels for pixel requests and sharpened responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsh_req_if import lsh_pkg::*; ();
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [WORD_W-1:0] pixel_word;

   modport source (output valid, kind, pixel_word, input ready);
   modport sink (input valid, kind, pixel_word, output ready);
endinterface

interface lsh_rsp_if import lsh_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;
   logic            frame_end;

   modport source (output valid, red, green, blue, frame_end, input ready);
   modport sink (input valid, red, green, blue, frame_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/lsh_line_store.sv]
// ----------------------------------------------------------------------------
// lsh_line_store
// Two row memories: newer row with two read ports, older row with write
// forwarding onto its read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_line_store import lsh_pkg::*; (
   input  logic             clock,
   input  logic             newer_we,
   input  logic [COL_W-1:0] newer_wa,
   input  logic [PIX_W-1:0] newer_wd,
   input  logic [COL_W-1:0] newer_ra_a,
   input  logic [COL_W-1:0] newer_ra_b,
   output logic [PIX_W-1:0] newer_rd_a,
   output logic [PIX_W-1:0] newer_rd_b,
   input  logic             older_we,
   input  logic [COL_W-1:0] older_wa,
   input  logic [PIX_W-1:0] older_wd,
   input  logic [COL_W-1:0] older_ra,
   output logic [PIX_W-1:0] older_rd
);

   logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
   logic [PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [PIX_W-1:0] newer_rd_a_ff;
   logic [PIX_W-1:0] newer_rd_b_ff;
   logic [PIX_W-1:0] older_rd_ff;

   always_ff @(posedge clock) begin
      if (newer_we) begin
         newer_mem[newer_wa] <= newer_wd;
      end
      newer_rd_a_ff <= newer_mem[newer_ra_a];
      newer_rd_b_ff <= newer_mem[newer_ra_b];
   end

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[older_wa] <= older_wd;
      end
      if (older_we && (older_wa == older_ra)) begin
         older_rd_ff <= older_wd;
      end else begin
         older_rd_ff <= older_mem[older_ra];
      end
   end

   assign newer_rd_a = newer_rd_a_ff;
   assign newer_rd_b = newer_rd_b_ff;
   assign older_rd   = older_rd_ff;

endmodule

`default_nettype wire

[hw/rtl/lsh_sharpen.sv]
// ----------------------------------------------------------------------------
// lsh_sharpen
// Per-channel four-neighbor Laplacian, clamped and added back to the centre.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_sharpen import lsh_pkg::*; (
   input  window_type       win,
   output logic [PIX_W-1:0] pixel
);

   function automatic logic [CH_W-1:0] sharpen_ch(
      input logic [CH_W-1:0] c,
      input logic [CH_W-1:0] u,
      input logic [CH_W-1:0] d,
      input logic [CH_W-1:0] l,
      input logic [CH_W-1:0] r
   );
      logic signed [CH_W+3:0] e;
      logic [CH_W-1:0]        ce;
      logic [CH_W:0]          s;
      e = $signed({2'b00, c, 2'b00}) - $signed({4'b0000, u}) - $signed({4'b0000, d})
          - $signed({4'b0000, l}) - $signed({4'b0000, r});
      if (e < 0) begin
         ce = '0;
      end else if (e > $signed({4'b0000, {CH_W{1'b1}}})) begin
         ce = '1;
      end else begin
         ce = e[CH_W-1:0];
      end
      s = {1'b0, c} + {1'b0, ce};
      return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
   endfunction

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         pixel[ch*CH_W +: CH_W] = sharpen_ch(win.centre[ch*CH_W +: CH_W],
                                             win.up[ch*CH_W +: CH_W],
                                             win.down[ch*CH_W +: CH_W],
                                             win.left[ch*CH_W +: CH_W],
                                             win.right[ch*CH_W +: CH_W]);
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lsh_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// lsh_rsp_fifo
// Small response queue that decouples the pipeline from output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_rsp_fifo import lsh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_item_type         push_item,
   input  logic                 pop_ready,
   output logic                 pop_valid,
   output rsp_item_type         pop_item,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_item_type         entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((count_ff < RSP_CNT_W'(RSP_DEPTH)) || pop))
      else $error("response queue overflow");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("response queue count out of range");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff < RSP_PTR_W'(RSP_DEPTH)) && (rd_ptr_ff < RSP_PTR_W'(RSP_DEPTH)))
      else $error("response queue pointer out of range");
`endif

endmodule

`default_nettype wire

[hw/rtl/laplacian_sharpen_3x3_core.sv]
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_core
// Streaming 3x3 Laplacian sharpen of a raster-order ARGB frame.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_if.ready is high, pixels and drain items
// alike; a response reaches rsp_if through the registered read of the row
// memories and the registered response queue. Row r-1 comes out while
// row r goes in, so a pixel of the first row gives no response; after the
// frame send frame_width drain items to read out the last row, the final one
// flagged frame_end. Frames narrower or shorter than three pass through
// unchanged, as do all border pixels. The two row memories (2048 x 24 each)
// hold no reset value and need no clearing pass: draining before any frame
// has been sent returns undefined pixels. A three-entry response queue keeps
// full rate when rsp_if.ready is high and throttles req_if.ready otherwise.
// Program frame_width and frame_height only while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_sharpen_3x3_core import lsh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   lsh_req_if.sink                req_if,
   lsh_rsp_if.source              rsp_if
);

   logic [WIDTH_REG_W-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_REG_W-1:0] frame_height_ff, frame_height_in;
   logic [COL_W-1:0]        column_count_ff, column_count_in;
   logic [ROW_W-1:0]        row_count_ff, row_count_in;
   logic [COL_W-1:0]        drain_count_ff, drain_count_in;
   logic                    s1_valid_ff;
   stage_type               s1_ff, s1_in;
   logic [PIX_W-1:0]        left_ff, left_in;

   logic [COL_W-1:0]        last_col;
   logic [ROW_W-1:0]        last_row;
   logic                    req_accept;
   logic                    is_drain;
   logic                    drain_last;
   logic                    interior;

   logic [PIX_W-1:0]        newer_rd_a, newer_rd_b, older_rd;
   window_type              win;
   logic [PIX_W-1:0]        sharp_pixel;
   logic [PIX_W-1:0]        out_pixel;
   logic                    push;
   logic                    s1_pixel;
   rsp_item_type            push_item, pop_item;
   logic [RSP_CNT_W-1:0]    fifo_count;

   // config registers
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         last_col = '0;
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(frame_width_ff - 1'b1);
      end
      if (frame_height_ff == '0) begin
         last_row = '0;
      end else if (32'(frame_height_ff) > HEIGHT_LIMIT) begin
         last_row = ROW_W'(HEIGHT_LIMIT - 1);
      end else begin
         last_row = ROW_W'(frame_height_ff - 1'b1);
      end
   end

   // stage 0: accept, issue reads, write newer row
   assign req_accept = req_if.valid && req_if.ready;
   assign is_drain   = (req_if.kind == KIND_DRAIN);
   assign drain_last = (drain_count_ff >= last_col);
   assign interior   = (row_count_ff >= ROW_W'(2)) && (row_count_ff <= last_row)
                       && (column_count_ff != '0) && (column_count_ff < last_col);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      drain_count_in  = drain_count_ff;
      if (req_accept) begin
         if (is_drain) begin
            drain_count_in = drain_last ? '0 : drain_count_ff + 1'b1;
         end else begin
            drain_count_in = '0;
            if (column_count_ff >= last_col) begin
               column_count_in = '0;
               row_count_in    = (row_count_ff >= last_row) ? '0 : row_count_ff + 1'b1;
            end else begin
               column_count_in = column_count_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      s1_in.kind      = req_if.kind;
      s1_in.emit      = is_drain || (row_count_ff != '0);
      s1_in.interior  = !is_drain && interior;
      s1_in.frame_end = is_drain && drain_last;
      s1_in.col       = column_count_ff;
      s1_in.down      = req_if.pixel_word[PIX_W-1:0];
   end

   lsh_line_store u_line_store (
      .clock      (clock),
      .newer_we   (req_accept && !is_drain),
      .newer_wa   (column_count_ff),
      .newer_wd   (req_if.pixel_word[PIX_W-1:0]),
      .newer_ra_a (is_drain ? drain_count_ff : column_count_ff),
      .newer_ra_b (column_count_ff + 1'b1),
      .newer_rd_a (newer_rd_a),
      .newer_rd_b (newer_rd_b),
      .older_we   (s1_valid_ff && s1_pixel),
      .older_wa   (s1_ff.col),
      .older_wd   (newer_rd_a),
      .older_ra   (column_count_ff),
      .older_rd   (older_rd)
   );

   // stage 1: compute, write older row, push response
   assign s1_pixel   = (s1_ff.kind == KIND_PIXEL);
   assign win.centre = newer_rd_a;
   assign win.up     = older_rd;
   assign win.down   = s1_ff.down;
   assign win.left   = left_ff;
   assign win.right  = newer_rd_b;

   lsh_sharpen u_sharpen (
      .win   (win),
      .pixel (sharp_pixel)
   );

   assign out_pixel = s1_ff.interior ? sharp_pixel : newer_rd_a;
   assign push      = s1_valid_ff && s1_ff.emit;
   assign left_in   = (s1_valid_ff && s1_pixel) ? newer_rd_a : left_ff;

   always_comb begin
      push_item.red       = out_pixel[3*CH_W-1:2*CH_W];
      push_item.green     = out_pixel[2*CH_W-1:CH_W];
      push_item.blue      = out_pixel[CH_W-1:0];
      push_item.frame_end = s1_ff.frame_end;
   end

   lsh_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop_ready (rsp_if.ready),
      .pop_valid (rsp_if.valid),
      .pop_item  (pop_item),
      .count     (fifo_count)
   );

   assign rsp_if.red       = pop_item.red;
   assign rsp_if.green     = pop_item.green;
   assign rsp_if.blue      = pop_item.blue;
   assign rsp_if.frame_end = pop_item.frame_end;

   // hold off requests unless queue has room for in-flight and new item
   assign req_if.ready = ((RSP_CNT_W+1)'(fifo_count) + (RSP_CNT_W+1)'(push))
                         < (RSP_CNT_W+1)'(RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         drain_count_ff  <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         drain_count_ff  <= drain_count_in;
         s1_valid_ff     <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= s1_in;
      left_ff <= left_in;
   end

`ifndef SYNTH
   a_interior_is_pixel: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.interior) |-> (s1_pixel && s1_ff.emit))
      else $error("interior flag on a non-emitting or drain item");

   a_frame_end_is_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.frame_end) |-> (s1_ff.kind == KIND_DRAIN))
      else $error("frame end on a pixel item");

   a_stage_tracks_column: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_drain) |=> (s1_valid_ff && (s1_ff.col == $past(column_count_ff))))
      else $error("stage column does not match accepted pixel");
`endif

endmodule

`default_nettype wire

[test/tb_laplacian_sharpen_3x3_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laplacian_sharpen_3x3_core
// Self-checking bench for the 3x3 Laplacian sharpen core: raster frames of
// random and saturating pixels, drain sequences and register settings from
// the smallest to the largest frame go in under random valid/ready pressure.
// A line-buffer model predicts every sharpened pixel, border pass-through and
// frame_end flag, and each response is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_laplacian_sharpen_3x3_core;
   import lsh_pkg::*;

   class sharpen_tracker;
      logic [PIX_W-1:0]        older_row [MAX_WIDTH];
      logic [PIX_W-1:0]        newer_row [MAX_WIDTH];
      bit                      newer_written [MAX_WIDTH];
      int unsigned             col_pos;
      int unsigned             row_pos;
      int unsigned             drain_pos;
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      rsp_item_type            pending_pixels [$];
      int unsigned             items_taken;
      int unsigned             pixels_checked;
      int unsigned             mismatches;

      function new();
         foreach (older_row[i]) begin
            older_row[i]     = '0;
            newer_row[i]     = '0;
            newer_written[i] = 1'b0;
         end
         col_pos        = 0;
         row_pos        = 0;
         drain_pos      = 0;
         width_reg      = WIDTH_RESET;
         height_reg     = HEIGHT_RESET;
         items_taken    = 0;
         pixels_checked = 0;
         mismatches     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FRAME_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
         end else if (idx == CSR_FRAME_HEIGHT) begin
            height_reg = data[HEIGHT_REG_W-1:0];
         end
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = width_reg;
         if (w < 1) w = 1;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = height_reg;
         if (h < 1) h = 1;
         if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
         return h;
      endfunction

      function int unsigned store_index(int unsigned i);
         return (i >= MAX_WIDTH) ? MAX_WIDTH - 1 : i;
      endfunction

      function bit drain_ok();
         return newer_written[store_index(drain_pos)];
      endfunction

      function bit at_frame_start();
         return (col_pos == 0) && (row_pos == 0);
      endfunction

      function int unsigned pending();
         return pending_pixels.size();
      endfunction

      function logic [CH_W-1:0] sharpen_channel(logic [CH_W-1:0] c, logic [CH_W-1:0] u,
                                                logic [CH_W-1:0] d, logic [CH_W-1:0] l,
                                                logic [CH_W-1:0] r);
         int lap;
         int sum;
         lap = 4 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
         if (lap < 0) lap = 0;
         if (lap > 255) lap = 255;
         sum = int'(c) + lap;
         if (sum > 255) sum = 255;
         return CH_W'(sum);
      endfunction

      function void push_pixel(logic [PIX_W-1:0] px, logic fe);
         rsp_item_type item;
         item.red       = px[23:16];
         item.green     = px[15:8];
         item.blue      = px[7:0];
         item.frame_end = fe;
         pending_pixels.push_back(item);
      endfunction

      function void take_request(kind_type kind, logic [WORD_W-1:0] word);
         int unsigned      w;
         int unsigned      h;
         int unsigned      c;
         logic             fe;
         logic [PIX_W-1:0] px;
         logic [PIX_W-1:0] centre;
         logic [PIX_W-1:0] up;
         logic [PIX_W-1:0] left;
         logic [PIX_W-1:0] right;
         logic [PIX_W-1:0] res;
         w = eff_width();
         h = eff_height();
         items_taken++;
         if (kind == KIND_DRAIN) begin
            fe = (drain_pos >= w - 1);
            push_pixel(newer_row[store_index(drain_pos)], fe);
            drain_pos = fe ? 0 : drain_pos + 1;
            return;
         end
         px = word[PIX_W-1:0];
         c = store_index(col_pos);
         drain_pos = 0;
         if (row_pos >= 1) begin
            centre = newer_row[c];
            res = centre;
            if (row_pos >= 2 && row_pos <= h - 1 && c >= 1 && c + 2 <= w) begin
               up    = older_row[c];
               left  = older_row[c - 1];
               right = newer_row[c + 1];
               res = {sharpen_channel(centre[23:16], up[23:16], px[23:16], left[23:16],
                                      right[23:16]),
                      sharpen_channel(centre[15:8], up[15:8], px[15:8], left[15:8],
                                      right[15:8]),
                      sharpen_channel(centre[7:0], up[7:0], px[7:0], left[7:0],
                                      right[7:0])};
            end
            push_pixel(res, 1'b0);
         end
         older_row[c]     = newer_row[c];
         newer_row[c]     = px;
         newer_written[c] = 1'b1;
         if (col_pos >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      endfunction

      function void compare_field(string field_name, logic [CH_W-1:0] want,
                                  logic [CH_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", field_name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(rsp_item_type got);
         rsp_item_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected rsp item: red %0h green %0h blue %0h frame_end %0b",
                   got.red, got.green, got.blue, got.frame_end);
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         pixels_checked++;
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("frame_end", CH_W'(want.frame_end), CH_W'(got.frame_end));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     req_idle_pct;
   int                     rsp_idle_pct;
   int                     rsp_hold_cycles;
   int unsigned            reg_writes;
   sharpen_tracker         tracker;

   lsh_req_if req_if ();
   lsh_rsp_if rsp_if ();

   laplacian_sharpen_3x3_core DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_if       (req_if),
      .rsp_if       (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type seen;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen.red       = rsp_if.red;
         seen.green     = rsp_if.green;
         seen.blue      = rsp_if.blue;
         seen.frame_end = rsp_if.frame_end;
         tracker.check_pixel(seen);
      end
   end

   initial begin
      #10ms;
      $display("laplacian_sharpen_3x3_core regression: fail");
      $finish;
   end

   function automatic logic [WORD_W-1:0] random_pixel();
      logic [WORD_W-1:0] p;
      p = $urandom;
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(3))
            0: p[8*i +: 8] = 8'h00;
            1: p[8*i +: 8] = 8'hFF;
            default: ;
         endcase
      end
      return p;
   endfunction

   task automatic send_item(kind_type kind, logic [WORD_W-1:0] word);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid      <= 1'b0;
         req_if.pixel_word <= $urandom;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.pixel_word <= word;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.take_request(kind, word);
   endtask

   task automatic wait_results_done(int settle_cycles);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (settle_cycles) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      tracker.write_reg(idx, data);
      reg_writes++;
   endtask

   task automatic configure(int unsigned w, int unsigned h);
      wait_results_done(4);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic send_frame(bit noisy, bit pause);
      int unsigned w;
      int unsigned n;
      int unsigned drains;
      int          pick;
      w = tracker.eff_width();
      n = 0;
      do begin
         if (noisy && $urandom_range(15) == 0) begin
            repeat ($urandom_range(1, 3))
               if (tracker.drain_ok()) send_item(KIND_DRAIN, $urandom);
         end
         send_item(KIND_PIXEL, random_pixel());
         n++;
         if (pause && n == 64) wait_results_done(0);
      end while (!tracker.at_frame_start());
      drains = w;
      if (noisy) begin
         pick = $urandom_range(2);
         if (pick == 1) drains = $urandom_range(0, w - 1);
         else if (pick == 2) drains = w + $urandom_range(1, w);
      end
      repeat (drains)
         if (tracker.drain_ok()) send_item(KIND_DRAIN, $urandom);
   endtask

   initial begin : stimulus
      logic [WORD_W-1:0] grid [12];
      int unsigned       goal;
      int unsigned       w;
      int unsigned       h;
      tracker           = new();
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = CSR_FRAME_WIDTH;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.kind       = KIND_PIXEL;
      req_if.pixel_word = '0;
      req_idle_pct      = 31;
      rsp_idle_pct      = 74;
      rsp_hold_cycles   = 0;
      reg_writes        = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // saturating interior pixels, partial drain with wrap, then shrink mid-frame
      grid = '{32'hFFFFFFFF, 32'h00000000, 32'hFF808080, 32'h12345678,
               32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hAA55AA55,
               32'h80808080, 32'h00000000, 32'hFFFFFFFF, 32'h7F7F7F7F};
      configure(4, 3);
      foreach (grid[i]) send_item(KIND_PIXEL, grid[i]);
      repeat (6) send_item(KIND_DRAIN, $urandom);
      for (int i = 0; i < 5; i++) send_item(KIND_PIXEL, grid[11 - i]);
      configure(2, 2);
      send_item(KIND_PIXEL, 32'hFFFFFFFF);
      repeat (2) send_item(KIND_DRAIN, 32'hFFFFFFFF);

      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 74 : 0;
         rsp_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 31 : 0;
         if (mode == 2) begin
            configure(24, 6);
            rsp_hold_cycles = 300;
            send_frame(1'b0, 1'b1);
         end
         goal = tracker.items_taken + 340;
         while (tracker.items_taken < goal) begin
            case ($urandom_range(9))
               0: w = 0;
               1: w = 1;
               2: w = 2;
               3: w = 3;
               default: w = $urandom_range(4, 24);
            endcase
            case ($urandom_range(5))
               0: h = 0;
               1: h = 1;
               2: h = 2;
               default: h = $urandom_range(3, 7);
            endcase
            configure(w, h);
            repeat ($urandom_range(1, 3)) send_frame($urandom_range(2) == 0, 1'b0);
         end
      end

      // largest register values: start of a full-width first row, then drain part of it
      configure(4095, 8191);
      repeat (40) send_item(KIND_PIXEL, random_pixel());
      repeat (8) send_item(KIND_DRAIN, $urandom);

      wait_results_done(8);
      $display("covered %0d input items, %0d checked pixels, %0d register writes",
               tracker.items_taken, tracker.pixels_checked, reg_writes);
      if (tracker.mismatches == 0) begin
         $display("laplacian_sharpen_3x3_core regression: pass");
      end else begin
         $display("laplacian_sharpen_3x3_core regression: fail");
      end
      $finish;
   end
endmodule
